### hdl/ifmt_pkg.sv
// ----------------------------------------------------------------------------
// ifmt_pkg - shared types and constants of the integer field formatter
// Digit slot counts, ASCII codes, the digit word passed from the digit
// generator to the character emitter, and the digit-to-ASCII function.
// ----------------------------------------------------------------------------
package ifmt_pkg;

    // Field limit default
    localparam int FIELD_MAX_DEF = 63;

    // Digit register: ten 4-bit slots cover 32-bit decimal and hex
    localparam int NUM_SLOTS  = 10;
    localparam int DIG_BITS   = 4 * NUM_SLOTS;
    localparam int VALUE_BITS = 32;

    // Conversion codes
    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    // ASCII codes
    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_LOWA  = 7'h61;

    // Digit word handed to the emitter
    typedef struct packed {
        logic [DIG_BITS-1:0] digits;       // most significant digit on top
        logic [3:0]          num_digits;   // significant digit count
        logic                neg;
        logic [5:0]          field_width;
        logic                has_precision;
        logic [5:0]          min_digits;
    } digit_word_t;

    // Map one digit (0..15) to lowercase ASCII
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10)
            c = CHAR_ZERO + {3'b000, d};
        else
            c = CHAR_LOWA + {3'b000, d - 4'd10};
        return c;
    endfunction

endpackage

### hdl/ifmt_digits.sv
// ----------------------------------------------------------------------------
// ifmt_digits - digit generator
// Converts the magnitude bit-serially to BCD (shift and add 3, one bit per
// cycle) or loads hex nibbles directly, then strips leading zero digits one
// slot per cycle to find the digit count.
// ----------------------------------------------------------------------------
module ifmt_digits
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 opcode,
    input  logic [31:0]          value,
    input  logic [5:0]           field_width,
    input  logic                 has_precision,
    input  logic [5:0]           min_digits,
    output logic                 busy,
    output logic                 word_valid,
    output ifmt_pkg::digit_word_t word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM
    } state_t;

    localparam int DB = ifmt_pkg::DIG_BITS;
    localparam int VB = ifmt_pkg::VALUE_BITS;

    state_t                  state_reg, state_next;
    logic                    done_reg, done_next;
    logic [4:0]              bit_cnt_reg, bit_cnt_next;
    logic [3:0]              lz_reg, lz_next;
    logic [VB-1:0]           bin_reg, bin_next;
    logic [DB-1:0]           dig_reg, dig_next;
    logic                    neg_reg, neg_next;
    logic [5:0]              width_reg, width_next;
    logic                    hasp_reg, hasp_next;
    logic [5:0]              prec_reg, prec_next;
    logic [DB-1:0]           adj;
    logic                    neg_in;
    logic [VB-1:0]           mag_in;

    // Add 3 to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < ifmt_pkg::NUM_SLOTS; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = dig_reg[4*i +: 4];
        end
    end

    assign neg_in = (opcode == ifmt_pkg::OP_DEC) && value[VB-1];
    assign mag_in = neg_in ? (~value + 32'd1) : value;

    // Sequence conversion and normalization
    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        lz_next      = lz_reg;
        bin_next     = bin_reg;
        dig_next     = dig_reg;
        neg_next     = neg_reg;
        width_next   = width_reg;
        hasp_next    = hasp_reg;
        prec_next    = prec_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next     = neg_in;
                    width_next   = field_width;
                    hasp_next    = has_precision;
                    prec_next    = min_digits;
                    bit_cnt_next = '0;
                    lz_next      = '0;
                    bin_next     = mag_in;
                    if (opcode == ifmt_pkg::OP_HEX)
                    begin
                        dig_next   = {{(DB-VB){1'b0}}, value};
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        dig_next   = '0;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                dig_next     = {adj[DB-2:0], bin_reg[VB-1]};
                bin_next     = {bin_reg[VB-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'(VB - 1))
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if ((dig_reg[DB-1 -: 4] != 4'd0) || (lz_reg == 4'(ifmt_pkg::NUM_SLOTS)))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    dig_next = {dig_reg[DB-5:0], 4'd0};
                    lz_next  = lz_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
            lz_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            bit_cnt_reg <= bit_cnt_next;
            lz_reg      <= lz_next;
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        dig_reg   <= dig_next;
        neg_reg   <= neg_next;
        width_reg <= width_next;
        hasp_reg  <= hasp_next;
        prec_reg  <= prec_next;
    end

    assign busy       = (state_reg != ST_IDLE) || done_reg;
    assign word_valid = done_reg;

    always_comb
    begin
        word.digits        = dig_reg;
        word.num_digits    = 4'(ifmt_pkg::NUM_SLOTS) - lz_reg;
        word.neg           = neg_reg;
        word.field_width   = width_reg;
        word.has_precision = hasp_reg;
        word.min_digits    = prec_reg;
    end

endmodule

### hdl/ifmt_emit.sv
// ----------------------------------------------------------------------------
// ifmt_emit - character emitter
// Sizes padding from the digit word, then loads one character per cycle
// (held by out_stall) into the output register: spaces, sign, zeros, digits.
// ----------------------------------------------------------------------------
module ifmt_emit
#(
    parameter int FIELD_MAX = ifmt_pkg::FIELD_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    input  ifmt_pkg::digit_word_t word,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [6:0]            character,
    output logic                  last
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam int DB = ifmt_pkg::DIG_BITS;
    localparam logic [5:0] WIDTH_LIM = 6'(FIELD_MAX);
    localparam logic [5:0] PREC_LIM  = 6'(FIELD_MAX - 1);

    state_t         state_reg, state_next;
    logic           ovalid_reg, ovalid_next;
    logic [5:0]     rem_reg, rem_next;
    logic [5:0]     sp_reg, sp_next;
    logic [5:0]     zr_reg, zr_next;
    logic           sign_reg, sign_next;
    logic [DB-1:0]  dig_reg, dig_next;
    logic [6:0]     char_reg, char_next;
    logic           last_reg, last_next;

    logic [5:0]     width_c, prec_a, prec_c, nd6, longest, body, total;
    logic           can_load;

    // Clamp width and precision, size the field
    always_comb
    begin
        width_c = (word.field_width > WIDTH_LIM) ? WIDTH_LIM : word.field_width;
        prec_a  = word.has_precision ? word.min_digits : 6'd1;
        prec_c  = (prec_a > PREC_LIM) ? PREC_LIM : prec_a;
        nd6     = {2'b00, word.num_digits};
        longest = (nd6 > prec_c) ? nd6 : prec_c;
        body    = longest + {5'd0, word.neg};
        total   = (width_c > body) ? width_c : body;
    end

    assign can_load = !ovalid_reg || !out_stall;

    // Pick the next character
    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && out_stall;
        rem_next    = rem_reg;
        sp_next     = sp_reg;
        zr_next     = zr_reg;
        sign_next   = sign_reg;
        dig_next    = dig_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (word_valid)
                begin
                    rem_next  = total;
                    sp_next   = total - body;
                    zr_next   = (prec_c > nd6) ? (prec_c - nd6) : 6'd0;
                    sign_next = word.neg;
                    dig_next  = word.digits;
                    if (total != 6'd0)
                        state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (can_load)
                begin
                    ovalid_next = 1'b1;
                    last_next   = (rem_reg == 6'd1);
                    rem_next    = rem_reg - 6'd1;
                    if (rem_reg == 6'd1)
                        state_next = ST_IDLE;
                    priority if (sp_reg != 6'd0)
                    begin
                        char_next = ifmt_pkg::CHAR_SPACE;
                        sp_next   = sp_reg - 6'd1;
                    end
                    else if (sign_reg)
                    begin
                        char_next = ifmt_pkg::CHAR_MINUS;
                        sign_next = 1'b0;
                    end
                    else if (zr_reg != 6'd0)
                    begin
                        char_next = ifmt_pkg::CHAR_ZERO;
                        zr_next   = zr_reg - 6'd1;
                    end
                    else
                    begin
                        char_next = ifmt_pkg::digit_char(dig_reg[DB-1 -: 4]);
                        dig_next  = {dig_reg[DB-5:0], 4'd0};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, padding counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            rem_reg    <= '0;
            sp_reg     <= '0;
            zr_reg     <= '0;
            sign_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            rem_reg    <= rem_next;
            sp_reg     <= sp_next;
            zr_reg     <= zr_next;
            sign_reg   <= sign_next;
        end
    end

    // Advance digit shifter and output word
    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg == ST_RUN);
    assign out_valid = ovalid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

### hdl/integer_field_formatter.sv
// Decimal values pass the bit-serial BCD shifter and hex values skip it; both
// then pass the slot-by-slot leading-zero strip before the first character is
// loaded into the output register, then one character per cycle (up to 63)
// when out_stall is low. The next word is accepted the cycle after the final
// character is loaded.
// Reset: all control cleared, no output word valid, input ready after reset.
// ----------------------------------------------------------------------------
// integer_field_formatter - printf-style %d / %x integer formatter
// Accepts one value with conversion code, width and precision, and emits
// the formatted ASCII characters one word each, flagging the last one.
// ----------------------------------------------------------------------------
module integer_field_formatter
#(
    parameter int FIELD_MAX = ifmt_pkg::FIELD_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] value,
    input  logic [5:0]  field_width,
    input  logic        has_precision,
    input  logic [5:0]  min_digits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  character,
    output logic        last
);

    logic                  dig_busy;
    logic                  emit_busy;
    logic                  word_valid;
    ifmt_pkg::digit_word_t word;
    logic                  start;

    // Take a word only when both stages are free
    assign in_stall = dig_busy || emit_busy;
    assign start    = in_valid && !in_stall;

    ifmt_digits u_digits
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (opcode),
        .value         (value),
        .field_width   (field_width),
        .has_precision (has_precision),
        .min_digits    (min_digits),
        .busy          (dig_busy),
        .word_valid    (word_valid),
        .word          (word)
    );

    ifmt_emit #(
        .FIELD_MAX (FIELD_MAX)
    ) u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .busy       (emit_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .character  (character),
        .last       (last)
    );

endmodule

### test/integer_field_formatter_checker.sv
// ----------------------------------------------------------------------------
// integer_field_formatter_checker - output predictor and scoreboard
// Watches both channels of the formatter. For each accepted input word it
// expands the conversion into the expected characters. Each accepted output
// word is compared with the oldest of them. Mismatches are counted, and the
// number of characters still outstanding is reported.
// ----------------------------------------------------------------------------
module integer_field_formatter_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] value,
    input  logic [5:0]  field_width,
    input  logic        has_precision,
    input  logic [5:0]  min_digits,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [6:0]  character,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    localparam int FIELD_LIMIT = ifmt_pkg::FIELD_MAX_DEF;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [6:0] glyph;
        logic       tail;
    } char_word_t;

    char_word_t expected_chars [$];
    int         errors = 0;

    assign fail_count = errors;

    // Expand one conversion into its characters and queue them in order
    function automatic void format_conversion(
        input logic        op,
        input logic [31:0] val,
        input logic [5:0]  width_in,
        input logic        prec_given,
        input logic [5:0]  prec_in
    );
        int unsigned width;
        int unsigned prec;
        int unsigned ndig;
        int unsigned body;
        int unsigned total;
        int unsigned i;
        logic [31:0] mag;
        logic        neg;
        logic [3:0]  digs [0:15];
        logic [3:0]  d;
        logic [6:0]  text [$];
        char_word_t  cw;

        width = (width_in > FIELD_LIMIT) ? FIELD_LIMIT : width_in;
        prec  = prec_given ? prec_in : 1;
        if (prec > FIELD_LIMIT - 1)
            prec = FIELD_LIMIT - 1;

        // Only decimal carries a sign
        neg = (op == ifmt_pkg::OP_DEC) && val[31];
        mag = neg ? -val : val;

        // Collect digits, least significant first
        ndig = 0;
        while (mag != 0) begin
            if (op == ifmt_pkg::OP_DEC) begin
                digs[ndig] = 4'(mag % 10);
                mag        = mag / 10;
            end
            else begin
                digs[ndig] = mag[3:0];
                mag        = mag >> 4;
            end
            ndig++;
        end

        body  = ((ndig > prec) ? ndig : prec) + (neg ? 1 : 0);
        total = (width > body) ? width : body;
        if (total > FIELD_LIMIT)
            total = FIELD_LIMIT;

        // Spaces, sign, zero fill, then digits from the top
        for (i = body; i < total; i++)
            text.push_back(ifmt_pkg::CHAR_SPACE);
        if (neg)
            text.push_back(ifmt_pkg::CHAR_MINUS);
        for (i = ndig; i < prec; i++)
            text.push_back(ifmt_pkg::CHAR_ZERO);
        for (i = ndig; i > 0; i--) begin
            d = digs[i - 1];
            text.push_back((d < 4'd10) ? ifmt_pkg::CHAR_ZERO + 7'(d)
                                       : ifmt_pkg::CHAR_LOWA + 7'(d - 4'd10));
        end

        foreach (text[k]) begin
            cw.glyph = text[k];
            cw.tail  = (k == text.size() - 1);
            expected_chars.push_back(cw);
        end
    endfunction

    // Check output words against the oldest expectation, then predict new input
    always @(posedge clk or negedge rst_n)
    begin
        char_word_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    if (errors < REPORT_MAX)
                        $display("mismatch: no character expected, got char %h last %b",
                                 character, last);
                    errors++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (character !== want.glyph || last !== want.tail)
                    begin
                        if (errors < REPORT_MAX)
                            $display("mismatch: expected char %h last %b, got char %h last %b",
                                     want.glyph, want.tail, character, last);
                        errors++;
                    end
                end
            end

            if (in_valid && !in_stall)
                format_conversion(opcode, value, field_width, has_precision, min_digits);

            pending <= expected_chars.size();
        end
    end

endmodule

### test/integer_field_formatter_tb.sv
// ----------------------------------------------------------------------------
// integer_field_formatter_tb - stimulus and verdict for the formatter
// Sends a directed set of conversions covering zero with zero precision,
// full width, clamped precision, sign extremes and both radixes, then a few
// hundred random ones. Both channels idle at random. A checker beside the
// block predicts every character and counts mismatches.
// ----------------------------------------------------------------------------
module integer_field_formatter_tb;

    localparam int          NUM_RANDOM = 430;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          IDLE_PCT = 17;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = ifmt_pkg::OP_DEC;
    logic [31:0] value = '0;
    logic [5:0]  field_width = '0;
    logic        has_precision = 1'b0;
    logic [5:0]  min_digits = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [6:0]  character;
    logic        last;
    logic        calm_out = 1'b0;

    int          chk_failures;
    int          chk_pending;
    int unsigned cycles = 0;

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    integer_field_formatter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .value         (value),
        .field_width   (field_width),
        .has_precision (has_precision),
        .min_digits    (min_digits),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .character     (character),
        .last          (last)
    );

    integer_field_formatter_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .value         (value),
        .field_width   (field_width),
        .has_precision (has_precision),
        .min_digits    (min_digits),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .character     (character),
        .last          (last),
        .fail_count    (chk_failures),
        .pending       (chk_pending)
    );

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("integer_field_formatter_tb NOT OK");
            $finish;
        end
    end

    // Stall the output at random, with a calm window
    always @(posedge clk)
    begin
        if (calm_out)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    // Offer one word, with an optional gap first, and hold it until taken
    task automatic send_conversion(
        input logic        op,
        input logic [31:0] val,
        input logic [5:0]  width,
        input logic        prec_given,
        input logic [5:0]  prec,
        input bit          calm
    );
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        value         <= val;
        field_width   <= width;
        has_precision <= prec_given;
        min_digits    <= prec;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        logic        op;
        logic [31:0] val;
        logic [5:0]  width;
        logic        prec_given;
        logic [5:0]  prec;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero cases, sign extremes, clamps, both radixes
        send_conversion(ifmt_pkg::OP_DEC, 32'd0,          6'd0,  1'b0, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'd0,          6'd0,  1'b1, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'd0,          6'd5,  1'b1, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_HEX, 32'd0,          6'd0,  1'b1, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_HEX, 32'd0,          6'd3,  1'b0, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'h8000_0000,  6'd0,  1'b0, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'h7fff_ffff,  6'd0,  1'b0, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'hffff_ffff,  6'd10, 1'b1, 6'd5,  1'b0);
        send_conversion(ifmt_pkg::OP_HEX, 32'hffff_ffff,  6'd0,  1'b0, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_HEX, 32'h8000_0000,  6'd12, 1'b0, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_HEX, 32'hdead_beef,  6'd63, 1'b1, 6'd62, 1'b0);
        send_conversion(ifmt_pkg::OP_DEC, -32'sd123,      6'd63, 1'b1, 6'd63, 1'b0);
        send_conversion(ifmt_pkg::OP_HEX, 32'h0000_000a,  6'd63, 1'b1, 6'd63, 1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'd0,          6'd0,  1'b1, 6'd63, 1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'hffff_ffff,  6'd0,  1'b0, 6'd40, 1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'd1,          6'd1,  1'b0, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'd9,          6'd0,  1'b1, 6'd1,  1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'd10,         6'd2,  1'b1, 6'd3,  1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'd999_999_999, 6'd0, 1'b0, 6'd0, 1'b0);
        send_conversion(ifmt_pkg::OP_DEC, 32'd1_000_000_000, 6'd11, 1'b0, 6'd0, 1'b0);
        send_conversion(ifmt_pkg::OP_DEC, -32'sd5,        6'd2,  1'b1, 6'd0,  1'b0);
        send_conversion(ifmt_pkg::OP_DEC, -32'sd7,        6'd1,  1'b1, 6'd3,  1'b0);
        send_conversion(ifmt_pkg::OP_HEX, 32'h0123_4567,  6'd20, 1'b1, 6'd9,  1'b0);
        send_conversion(ifmt_pkg::OP_HEX, 32'h89ab_cdef,  6'd4,  1'b1, 6'd2,  1'b0);

        // Random conversions, no idling on either side in a middle stretch
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            op = 1'($urandom_range(1));
            case ($urandom_range(5))
                0: val = $urandom;
                1: val = $urandom_range(15);
                2: val = $urandom >> $urandom_range(31);
                3: val = -$urandom_range(1000, 1);
                4: val = $urandom_range(1) ? 32'h7fff_fffe + $urandom_range(3)
                                           : 32'hffff_fffc + $urandom_range(3);
                default: val = '0;
            endcase
            width      = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                  : 6'($urandom_range(12));
            prec_given = 1'($urandom_range(1));
            prec       = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                  : 6'($urandom_range(12));
            calm_out  <= (n >= 200 && n < 300);
            send_conversion(op, val, width, prec_given, prec, n >= 200 && n < 300);
        end
        in_valid <= 1'b0;
        calm_out <= 1'b0;

        // Drain outstanding characters, then watch for strays
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (chk_failures == 0 && chk_pending == 0)
            $display("integer_field_formatter_tb OK");
        else
            $display("integer_field_formatter_tb NOT OK");
        $finish;
    end

endmodule

### integer_field_formatter.f
hdl/ifmt_pkg.sv
hdl/ifmt_digits.sv
hdl/ifmt_emit.sv
hdl/integer_field_formatter.sv
test/integer_field_formatter_checker.sv
test/integer_field_formatter_tb.sv
